[hdl/cnn_pkg.sv]
`timescale 1ns / 1ps
package cnn_pkg;

  // Scramble and hash multipliers.
  localparam logic [31:0] MIX_C1    = 32'h7FEB352D;
  localparam logic [31:0] MIX_C2    = 32'h846CA68B;
  localparam logic [31:0] HASH_GOLD = 32'h9E3779B9;
  localparam logic [31:0] HASH_CX   = 32'h85EBCA6B;
  localparam logic [31:0] HASH_CY   = 32'hC2B2AE35;
  localparam logic [31:0] HASH_CZ   = 32'h27D4EB2F;

  // Jitter is round((0.11 + 0.78 * m / UNIT_DEN) * 2^F), done exactly in integers.
  localparam int unsigned UNIT_DEN   = 32'd16777215;
  localparam logic [30:0] JIT_SCALE  = 31'd78;
  localparam logic [30:0] JIT_BASE   = 31'd184549365;  // 11 * UNIT_DEN
  localparam logic [31:0] HALF_DEN   = 32'd838860750;  // 100 * UNIT_DEN / 2
  localparam int          WIDE_W     = 56;
  localparam logic [31:0] RECIP_100  = 32'h51EB851F;
  localparam int          RECIP_SHR  = 37;

  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_INV_CELL = 1'b0;
  localparam reg_index_t REG_SEED     = 1'b1;

  // Per-cell control that travels down the cell pipeline.
  typedef struct packed {
    logic            first;
    logic            last;
    logic [2:0][1:0] off;    // signed neighbor offsets, z y x from the top
  } cell_tag_t;

  function automatic logic [31:0] xs16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [31:0] xs15(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  function automatic logic [31:0] mix_a(input logic [31:0] v);
    return 32'(xs16(v) * MIX_C1);
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] v);
    return 32'(xs15(v) * MIX_C2);
  endfunction

endpackage

[hdl/cellular_noise_nearest_two_unit.sv]
`timescale 1ns / 1ps
// The single cell pipeline takes one neighbor cell per cycle unless a finished
// word waits downstream, and a following point is scaled while it works.
// Reset (synchronous, active high) empties the pipeline and sets the cell
// scale to 1.0 and the seed to 0.
module cellular_noise_nearest_two_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [111:0]        m_axis_tdata,   // nearest_sq_dist, second_sq_dist,
                                              // nearest_cell_hash, zero fill
  input  logic                cfg_we,
  input  cnn_pkg::reg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import cnn_pkg::*;

  localparam int F = FRACTION_BITS;

  logic [31:0] inv_cell, seed;
  logic        en;

  logic                pt_valid, pt_ready;
  logic [2:0][31:0]    pt_cell;
  logic [2:0][F-1:0]   pt_frac;

  logic                c_valid;
  logic [2:0][31:0]    c_cell;
  cell_tag_t           c_tag;
  logic [2:0][F-1:0]   c_frac;

  logic                d_valid;
  cell_tag_t           d_tag;
  logic [2*F+3:0]      d_dist;
  logic [31:0]         d_hash;

  logic [36:0] nearest_sq_dist, second_sq_dist;
  logic [31:0] nearest_cell_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell <= 32'd65536;
      seed     <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_CELL: inv_cell <= cfg_data;
        REG_SEED:     seed     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // The whole cell pipeline holds while a finished word waits downstream.
  assign en = !m_axis_tvalid || m_axis_tready;

  cnn_scale #(.FRACTION_BITS(F)) u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .pos      ({s_axis_tdata[95:64], s_axis_tdata[63:32], s_axis_tdata[31:0]}),
    .inv_cell (inv_cell),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .grid     (pt_cell),
    .frac     (pt_frac)
  );

  cnn_seq #(.FRACTION_BITS(F)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .cell_in   (pt_cell),
    .frac_in   (pt_frac),
    .out_valid (c_valid),
    .out_cell  (c_cell),
    .out_tag   (c_tag),
    .out_frac  (c_frac)
  );

  cnn_cell_pipe #(.FRACTION_BITS(F)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_cell   (c_cell),
    .in_tag    (c_tag),
    .in_frac   (c_frac),
    .seed      (seed),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .out_dist  (d_dist),
    .out_hash  (d_hash)
  );

  cnn_reduce #(.FRACTION_BITS(F)) u_reduce (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .in_valid          (d_valid),
    .in_tag            (d_tag),
    .in_dist           (d_dist),
    .in_hash           (d_hash),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .nearest_sq_dist   (nearest_sq_dist),
    .second_sq_dist    (second_sq_dist),
    .nearest_cell_hash (nearest_cell_hash)
  );

  assign m_axis_tdata = {6'b0, nearest_cell_hash, second_sq_dist, nearest_sq_dist};

endmodule

[hdl/cnn_scale.sv]
`timescale 1ns / 1ps
module cnn_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0][31:0]                     pos,
  input  logic [31:0]                          inv_cell,
  output logic                                 pt_valid,
  input  logic                                 pt_ready,
  output logic [2:0][31:0]                     grid,
  output logic [2:0][FRACTION_BITS-1:0]        frac
);
  import cnn_pkg::*;

  localparam int F = FRACTION_BITS;

  logic v1, v2, adv, ld1;
  logic signed [64:0] prod [3];
  logic signed [64:0] q [3];
  logic signed [31:0] sat [3];

  assign adv      = !v2 || pt_ready;
  assign ld1      = !v1 || adv;
  assign in_ready = ld1;
  assign pt_valid = v2;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      q[a] = prod[a] >>> F;
      if (q[a] > 65'sd2147483647) begin
        sat[a] = 32'sh7FFFFFFF;
      end else if (q[a] < -65'sd2147483648) begin
        sat[a] = 32'sh80000000;
      end else begin
        sat[a] = 32'(q[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (adv) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (ld1) prod[a] <= $signed(pos[a]) * $signed({1'b0, inv_cell});
      if (adv) begin
        grid[a] <= 32'(sat[a] >>> F);
        frac[a] <= sat[a][F-1:0];
      end
    end
  end

endmodule

[hdl/cnn_seq.sv]
`timescale 1ns / 1ps
module cnn_seq #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  logic [2:0][31:0]              cell_in,
  input  logic [2:0][FRACTION_BITS-1:0] frac_in,
  output logic                          out_valid,
  output logic [2:0][31:0]              out_cell,
  output cnn_pkg::cell_tag_t            out_tag,
  output logic [2:0][FRACTION_BITS-1:0] out_frac
);
  import cnn_pkg::*;

  logic                          busy, is_last;
  logic [2:0][1:0]               cnt;   // z y x counters, 0..2
  logic [2:0][1:0]               off;
  logic [2:0][31:0]              cur_cell;
  logic [2:0][FRACTION_BITS-1:0] cur_frac;

  assign is_last  = (cnt[0] == 2'd2) && (cnt[1] == 2'd2) && (cnt[2] == 2'd2);
  assign pt_ready = en && (!busy || is_last);

  always_comb begin
    for (int a = 0; a < 3; a++) off[a] = 2'(cnt[a] - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (en) begin
      out_valid <= busy;
      if (pt_ready) begin
        busy <= pt_valid;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt[0] == 2'd2) begin
          cnt[0] <= 2'd0;
          if (cnt[1] == 2'd2) begin
            cnt[1] <= 2'd0;
            cnt[2] <= 2'(cnt[2] + 2'd1);
          end else begin
            cnt[1] <= 2'(cnt[1] + 2'd1);
          end
        end else begin
          cnt[0] <= 2'(cnt[0] + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        out_cell[a] <= cur_cell[a] + 32'($signed(off[a]));
      end
      out_frac      <= cur_frac;
      out_tag.first <= (cnt == '0);
      out_tag.last  <= is_last;
      out_tag.off   <= off;
      if (pt_ready && pt_valid) begin
        cur_cell <= cell_in;
        cur_frac <= frac_in;
      end
    end
  end

endmodule

[hdl/cnn_cell_pipe.sv]
`timescale 1ns / 1ps
module cnn_cell_pipe #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][31:0]              in_cell,
  input  cnn_pkg::cell_tag_t            in_tag,
  input  logic [2:0][FRACTION_BITS-1:0] in_frac,
  input  logic [31:0]                   seed,
  output logic                          out_valid,
  output cnn_pkg::cell_tag_t            out_tag,
  output logic [2*FRACTION_BITS+3:0]    out_dist,
  output logic [31:0]                   out_hash
);
  import cnn_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int DLW = F + 3;
  localparam int SQW = 2 * F + 2;
  localparam int DSW = 2 * F + 4;
  localparam int NT  = 15;
  localparam int NH  = 8;
  localparam int NF  = 12;

  cell_tag_t                     tag [NT];
  logic [NT-1:0]                 vld;
  logic [NF-1:0][2:0][F-1:0]     frac_p;
  logic [NH-1:0][31:0]           hp;

  logic [31:0] mx1, my1, mz1, b2, my2, mz2, d3, my3, mz3, b4, mz4, d5, mz5, b6, d7;
  logic [2:0][31:0]       b8, d9, q11;
  logic [2:0][WIDE_W-1:0] w10;
  logic [2:0][63:0]       p12;
  logic signed [DLW-1:0]  dl13 [3];
  logic [2:0][SQW-1:0]    sq14;
  logic [DSW-1:0]         dist15;

  logic [31:0]           h8_next;
  logic [2:0][31:0]      q11_next;
  logic [2:0][WIDE_W-1:0] w10_next;
  logic signed [DLW-1:0] dl13_next [3];
  logic signed [2*DLW-1:0] sq_full [3];

  // Offsets added to the cell hash before the three axis scrambles.
  localparam logic [2:0][31:0] JIT_ADD = {32'd13, 32'd7, 32'd1};

  assign h8_next = xs16(d7);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [31:0] jh;
      logic [23:0] m;
      logic [30:0] u;
      logic [7:0]  w2;
      logic [23:0] w1, w0;
      logic [25:0] s;
      logic [2:0]  qp;
      logic [F:0]  j;
      jh = xs16(d9[l]);
      m  = jh[23:0];
      u  = 31'(31'(m) * JIT_SCALE) + JIT_BASE;
      w10_next[l] = (WIDE_W'(u) << F) + WIDE_W'(HALF_DEN);
      // Split the wide word in 24-bit digits; 2^24 is one more than the divisor.
      w2 = w10[l][55:48];
      w1 = w10[l][47:24];
      w0 = w10[l][23:0];
      s  = 26'(w2) + 26'(w1) + 26'(w0);
      qp = 3'((s + 26'(s >> 24) + 26'd1) >> 24);
      q11_next[l] = 32'({w2, 24'b0}) + 32'(w2) + 32'(w1) + 32'(qp);
      j = p12[l][RECIP_SHR +: F + 1];
      dl13_next[l] = $signed({tag[11].off[l][1], tag[11].off[l], {F{1'b0}}})
                   + $signed({2'b00, j})
                   - $signed({3'b000, frac_p[11][l]});
      sq_full[l] = dl13[l] * dl13[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0]    <= in_tag;
      frac_p[0] <= in_frac;
      for (int k = 1; k < NT; k++) tag[k] <= tag[k-1];
      for (int k = 1; k < NF; k++) frac_p[k] <= frac_p[k-1];
      hp[0] <= h8_next;
      for (int k = 1; k < NH; k++) hp[k] <= hp[k-1];

      mx1 <= 32'(in_cell[0] * HASH_CX);
      my1 <= 32'(in_cell[1] * HASH_CY);
      mz1 <= 32'(in_cell[2] * HASH_CZ);
      b2  <= mix_a(seed ^ HASH_GOLD ^ mx1);
      my2 <= my1;
      mz2 <= mz1;
      d3  <= mix_b(b2);
      my3 <= my2;
      mz3 <= mz2;
      b4  <= mix_a(xs16(d3) ^ my3);
      mz4 <= mz3;
      d5  <= mix_b(b4);
      mz5 <= mz4;
      b6  <= mix_a(xs16(d5) ^ mz5);
      d7  <= mix_b(b6);
      for (int l = 0; l < 3; l++) begin
        b8[l]   <= mix_a(h8_next + JIT_ADD[l]);
        d9[l]   <= mix_b(b8[l]);
        w10[l]  <= w10_next[l];
        q11[l]  <= q11_next[l];
        p12[l]  <= 64'(q11[l]) * 64'(RECIP_100);
        dl13[l] <= dl13_next[l];
        sq14[l] <= sq_full[l][SQW-1:0];
      end
      dist15 <= DSW'(sq14[0]) + DSW'(sq14[1]) + DSW'(sq14[2]);
    end
  end

  assign out_valid = vld[NT-1];
  assign out_tag   = tag[NT-1];
  assign out_dist  = dist15;
  assign out_hash  = hp[NH-1];

endmodule

[hdl/cnn_reduce.sv]
`timescale 1ns / 1ps
module cnn_reduce #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  cnn_pkg::cell_tag_t         in_tag,
  input  logic [2*FRACTION_BITS+3:0] in_dist,
  input  logic [31:0]                in_hash,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [36:0]                nearest_sq_dist,
  output logic [36:0]                second_sq_dist,
  output logic [31:0]                nearest_cell_hash
);
  import cnn_pkg::*;

  localparam int DSW = 2 * FRACTION_BITS + 4;
  localparam int RS  = (2 * FRACTION_BITS >= 32) ? (2 * FRACTION_BITS - 32) : 0;
  localparam int LS  = (2 * FRACTION_BITS >= 32) ? 0 : (32 - 2 * FRACTION_BITS);

  logic [DSW-1:0] best, second, cb, cs, best_next, second_next;
  logic [31:0]    bh, bh_next;

  always_comb begin
    cb = in_tag.first ? '1 : best;
    cs = in_tag.first ? '1 : second;
    best_next   = cb;
    second_next = cs;
    bh_next     = bh;
    // Strict compares keep the earlier cell on a tie.
    if (in_dist < cb) begin
      best_next   = in_dist;
      second_next = cb;
      bh_next     = in_hash;
    end else if (in_dist < cs) begin
      second_next = in_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && in_valid && in_tag.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      best   <= best_next;
      second <= second_next;
      bh     <= bh_next;
      if (in_tag.last) begin
        nearest_sq_dist   <= 37'((64'(best_next) >> RS) << LS);
        second_sq_dist    <= 37'((64'(second_next) >> RS) << LS);
        nearest_cell_hash <= bh_next;
      end
    end
  end

endmodule
